>>> rtl/core/wbd_pkg.sv
// Shared types and constants for the watershed boundary detector.
// No dependencies; wbd_front, wbd_queue, wbd_back and the top level import this package.
`default_nettype none

package wbd_pkg;

  localparam int MAX_COLS_DEF = 1024;

  localparam int LABEL_W     = 32;
  localparam int ELEV_W      = 16;
  localparam int ROW_W       = 16;
  localparam int ROWCNT_W    = ROW_W + 1;   // arrival row may run one past row_count
  localparam int OUT_COL_W   = 10;
  localparam int OUT_LABEL_W = 31;
  localparam int COLCFG_W    = 11;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int WIN_N       = 9;

  // center queue; depth must be a power of two (pointers wrap freely)
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = CFG_IDX_W'(1);

  localparam logic [LABEL_W-1:0] LABEL_UNDEF = {LABEL_W{1'b1}};
  localparam logic [LABEL_W-1:0] LABEL_EDGE  = '0;

  typedef struct packed {
    logic [LABEL_W-1:0]       label;
    logic signed [ELEV_W-1:0] elev;
  } cell_t;

  // one evaluated center: a hit bit per window position plus resolved fields
  typedef struct packed {
    logic [ROW_W-1:0]                    row;
    logic [OUT_COL_W-1:0]                col;
    logic [OUT_LABEL_W-1:0]              center;
    logic [WIN_N-1:0]                    hits;
    logic [WIN_N-1:0][OUT_LABEL_W-1:0]   other;
    logic [WIN_N-1:0][ELEV_W-1:0]        elev;
  } rec_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } qstat_t;

endpackage

`default_nettype wire

>>> rtl/core/wbd_div.sv
// Restoring divider, one quotient bit per cycle, for position renormalization.
// Depends on nothing but its parameters.
`default_nettype none

module wbd_div #(
  parameter int DVD_W = 10,
  parameter int DVS_W = 11
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  input  wire logic [DVD_W-1:0]  dividend,
  input  wire logic [DVS_W-1:0]  divisor,
  output logic                   busy,
  output logic [DVD_W-1:0]       quotient,
  output logic [DVS_W-1:0]       remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   trial;
  logic             fits;

  always_comb begin
    trial = {remainder, quotient[DVD_W-1]};
    fits  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DVD_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
    end else if (busy) begin
      remainder <= fits ? DVS_W'(trial - {1'b0, divisor}) : trial[DVS_W-1:0];
      quotient  <= {quotient[DVD_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/wbd_front.sv
// Front end: config registers, arrival position, line buffers, 3x3 window and
// per-center classification. Uses wbd_pkg and wbd_div; pushes into wbd_queue.
`default_nettype none

module wbd_front import wbd_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_write,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  input  wire                          cell_valid,
  output logic                         cell_stall,
  input  wire                          mode,
  input  wire logic [LABEL_W-1:0]      cell_label,
  input  wire logic signed [ELEV_W-1:0] cell_elevation,
  input  wire qstat_t                  q_stat,
  output logic                         q_push,
  output rec_t                         q_rec
);

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int NC_W  = $clog2(MAX_COLS + 1);
  localparam int CC_W  = (NC_W > COLCFG_W) ? NC_W : COLCFG_W;
  localparam int PR_W  = ROWCNT_W + 1;

  // configuration
  logic [ROW_W-1:0]    row_count;
  logic [COLCFG_W-1:0] col_count;
  logic                cfg_wr_d;
  logic [NC_W-1:0]     nc;
  logic [ROW_W-1:0]    nr;
  logic [CC_W-1:0]     cc_ext;

  // arrival position
  logic [ROWCNT_W-1:0] row;
  logic [COL_W-1:0]    col;

  // renormalization after a config change
  logic                div_busy;
  logic [COL_W-1:0]    div_q;
  logic [NC_W-1:0]     div_r_full;

  // position math at accept
  logic                accept;
  logic                over;
  logic [PR_W-1:0]     pr;
  logic [COL_W-1:0]    pc;
  logic                warm;
  logic [PR_W-1:0]     ctr_r;
  logic [COL_W-1:0]    ctr_c;
  logic                lost;
  logic                last_cell;
  logic [NC_W-1:0]     col_inc;
  cell_t               cur;

  // stage 1 (line buffer read data is available here)
  logic                s1_v;
  logic [COL_W-1:0]    s1_slot;
  cell_t               s1_cur;
  logic                s1_eval;
  logic [ROW_W-1:0]    s1_row;
  logic [OUT_COL_W-1:0] s1_col;
  logic                s1_top, s1_bot, s1_lft, s1_rgt;
  logic                s1_byp;
  cell_t               byp_up, byp_mid;
  cell_t               up_rd, mid_rd;
  cell_t               up_eff, mid_eff;

  cell_t               upper_mem  [MAX_COLS];
  cell_t               middle_mem [MAX_COLS];
  cell_t               win [2][3];   // [older, newer column][top..bottom]

  cell_t               nb [WIN_N];
  cell_t               ctr;
  logic                on_edge;
  logic [WIN_N-1:0]    hits;
  logic [WIN_N-1:0][OUT_LABEL_W-1:0] other;
  logic [WIN_N-1:0][ELEV_W-1:0]      elev;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= ROW_W'(1);
      col_count <= COLCFG_W'(1);
      cfg_wr_d  <= 1'b0;
    end else begin
      cfg_wr_d <= cfg_write;
      if (cfg_write) begin
        case (cfg_index)
          REG_ROW_COUNT: row_count <= cfg_data[ROW_W-1:0];
          REG_COL_COUNT: col_count <= cfg_data[COLCFG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    cc_ext = CC_W'(col_count);
    if (cc_ext == '0) begin
      nc = NC_W'(1);
    end else if (cc_ext > CC_W'(MAX_COLS)) begin
      nc = NC_W'(MAX_COLS);
    end else begin
      nc = NC_W'(cc_ext);
    end
    nr = (row_count == '0) ? ROW_W'(1) : row_count;
  end

  // column may sit past a shrunken col_count; split it once per config change
  wbd_div #(
    .DVD_W (COL_W),
    .DVS_W (NC_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cfg_wr_d),
    .dividend  (col),
    .divisor   (nc),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_r_full)
  );

  // ---------------- accept side ----------------
  always_comb begin
    cell_stall = cfg_write || cfg_wr_d || div_busy ||
                 (({1'b0, q_stat.count} + (QCNT_W + 1)'(s1_v)) >=
                  (QCNT_W + 1)'(QUEUE_DEPTH));
    accept = cell_valid && !cell_stall;

    if (mode) begin
      cur.label = LABEL_UNDEF;
      cur.elev  = '0;
    end else begin
      cur.label = cell_label;
      cur.elev  = cell_elevation;
    end

    // arrival index split as (pr, pc) over the effective column count
    over = NC_W'(col) >= nc;
    pr   = over ? (PR_W'(row) + PR_W'(div_q)) : PR_W'(row);
    pc   = over ? COL_W'(div_r_full) : col;
    warm = (pr == '0) || ((pr == PR_W'(1)) && (pc == '0));

    // center lags arrival by nc + 1
    if (pc != '0) begin
      ctr_r = pr - PR_W'(1);
      ctr_c = pc - COL_W'(1);
    end else begin
      ctr_r = pr - PR_W'(2);
      ctr_c = COL_W'(nc - NC_W'(1));
    end
    lost      = !warm && (ctr_r >= PR_W'(nr));
    last_cell = !warm && !lost && (ctr_r == PR_W'(nr) - PR_W'(1)) &&
                (NC_W'(ctr_c) == nc - NC_W'(1));
    col_inc   = NC_W'(col) + NC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (accept) begin
      if (lost || last_cell) begin
        row <= '0;
        col <= '0;
      end else if (col_inc >= nc) begin
        row <= row + ROWCNT_W'(1);
        col <= '0;
      end else begin
        col <= COL_W'(col_inc);
      end
    end
  end

  // ---------------- line buffers ----------------
  always_comb begin
    up_eff  = s1_byp ? byp_up  : up_rd;
    mid_eff = s1_byp ? byp_mid : mid_rd;
  end

  always_ff @(posedge clk) begin
    if (s1_v) begin
      upper_mem[s1_slot]  <= mid_eff;
      middle_mem[s1_slot] <= s1_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      up_rd  <= upper_mem[col];
      mid_rd <= middle_mem[col];
    end
  end

  // ---------------- stage 1 registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_slot <= col;
      s1_cur  <= cur;
      s1_eval <= !warm && !lost;
      s1_row  <= ROW_W'(ctr_r);
      s1_col  <= OUT_COL_W'(ctr_c);
      s1_top  <= ctr_r == '0;
      s1_bot  <= ctr_r == PR_W'(nr) - PR_W'(1);
      s1_lft  <= ctr_c == '0;
      s1_rgt  <= NC_W'(ctr_c) == nc - NC_W'(1);
      // same slot written this edge: take the values being written
      s1_byp  <= s1_v && (s1_slot == col);
      byp_up  <= mid_eff;
      byp_mid <= s1_cur;
    end
  end

  // ---------------- window ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 2; c++) begin
        for (int r = 0; r < 3; r++) begin
          win[c][r].label <= LABEL_UNDEF;
          win[c][r].elev  <= '0;
        end
      end
    end else if (s1_v) begin
      win[0]    <= win[1];
      win[1][0] <= up_eff;
      win[1][1] <= mid_eff;
      win[1][2] <= s1_cur;
    end
  end

  // ---------------- classification ----------------
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nb[r]     = win[0][r];
      nb[3 + r] = win[1][r];
    end
    nb[6]   = up_eff;
    nb[7]   = mid_eff;
    nb[8]   = s1_cur;
    ctr     = win[1][1];
    on_edge = s1_top || s1_bot || s1_lft || s1_rgt;

    for (int dc = 0; dc < 3; dc++) begin
      for (int dr = 0; dr < 3; dr++) begin
        logic outside;
        logic pair;
        outside = ((dr == 0) && s1_top) || ((dr == 2) && s1_bot) ||
                  ((dc == 0) && s1_lft) || ((dc == 2) && s1_rgt);
        pair    = !outside && (nb[dc*3 + dr].label != LABEL_UNDEF) &&
                  (nb[dc*3 + dr].label != ctr.label);
        hits[dc*3 + dr]  = pair || (on_edge && (ctr.label != LABEL_EDGE));
        other[dc*3 + dr] = pair ? nb[dc*3 + dr].label[OUT_LABEL_W-1:0] : '0;
        if (pair && ($signed(nb[dc*3 + dr].elev) > $signed(ctr.elev))) begin
          elev[dc*3 + dr] = nb[dc*3 + dr].elev;
        end else begin
          elev[dc*3 + dr] = ctr.elev;
        end
      end
    end

    q_push       = s1_v && s1_eval && (ctr.label != LABEL_UNDEF) && (hits != '0);
    q_rec.row    = s1_row;
    q_rec.col    = s1_col;
    q_rec.center = ctr.label[OUT_LABEL_W-1:0];
    q_rec.hits   = hits;
    q_rec.other  = other;
    q_rec.elev   = elev;
  end

endmodule

`default_nettype wire

>>> rtl/core/wbd_queue.sv
// Short FIFO of evaluated centers between front and back end.
// Uses wbd_pkg (rec_t, qstat_t, QUEUE_DEPTH).
`default_nettype none

module wbd_queue import wbd_pkg::*; (
  input  wire          clk,
  input  wire          rst,
  input  wire          push,
  input  wire rec_t    push_rec,
  input  wire          pop,
  output rec_t         head,
  output qstat_t       stat
);

  rec_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_comb begin
    head       = mem[rd_ptr];
    stat.count = count;
    stat.empty = count == '0;
  end

endmodule

`default_nettype wire

>>> rtl/core/wbd_back.sv
// Back end: expands each queued center into its records, one per cycle while
// rec_stall is low, through a registered output stage. Uses wbd_pkg; pops wbd_queue.
`default_nettype none

module wbd_back import wbd_pkg::*; (
  input  wire                          clk,
  input  wire                          rst,
  input  wire rec_t                    head,
  input  wire qstat_t                  q_stat,
  output logic                         pop,
  output logic                         rec_valid,
  input  wire                          rec_stall,
  output logic [ROW_W-1:0]             out_row,
  output logic [OUT_COL_W-1:0]         out_col,
  output logic [OUT_LABEL_W-1:0]       center_label,
  output logic signed [ELEV_W-1:0]     boundary_elevation,
  output logic [OUT_LABEL_W-1:0]       other_label,
  output logic                         last_of_run
);

  logic [WIN_N-1:0]       issued;
  logic [WIN_N-1:0]       pending;
  logic [WIN_N-1:0]       pick;
  logic                   last;
  logic                   load;
  logic [OUT_LABEL_W-1:0] sel_other;
  logic [ELEV_W-1:0]      sel_elev;

  always_comb begin
    pending = head.hits & ~issued;
    pick    = pending & (~pending + WIN_N'(1));   // lowest pending position
    last    = (pending & ~pick) == '0;
    load    = !q_stat.empty && (!rec_valid || !rec_stall);
    pop     = load && last;

    sel_other = '0;
    sel_elev  = '0;
    for (int k = 0; k < WIN_N; k++) begin
      sel_other = sel_other | (head.other[k] & {OUT_LABEL_W{pick[k]}});
      sel_elev  = sel_elev  | (head.elev[k]  & {ELEV_W{pick[k]}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
      issued    <= '0;
    end else if (load) begin
      rec_valid <= 1'b1;
      issued    <= last ? '0 : (issued | pick);
    end else if (!rec_stall) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_row            <= head.row;
      out_col            <= head.col;
      center_label       <= head.center;
      boundary_elevation <= sel_elev;
      other_label        <= sel_other;
      last_of_run        <= last;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/watershed_boundary_detect.sv
// Watershed boundary detector, top level. Instantiates wbd_front, wbd_queue
// and wbd_back; all types and constants come from wbd_pkg.
//
// Cells arrive in row order, one request per cycle when nothing pushes back;
// mode high marks a flush tick, which stands for a cell past the last row.
// The center being judged lags the newest cell by col_count + 1 positions, so
// a frame is row_count * col_count cells followed by col_count + 1 flush
// ticks. A defined center gives up to nine boundary records, sent in window
// order (left column first, top to bottom) with last_of_run on the final one.
// The front end reads both line buffers at the column of each arriving cell
// and writes them back in the following cycle, so cells are taken at one per
// cycle; the back end drains one record per cycle while rec_stall is low, so
// the sustained input rate is one cell per cycle while records average at most
// one per cell, and drops to the record rate when they are denser. A four-entry
// center queue absorbs bursts; cell_stall rises when it cannot take another
// center. A register write holds cell_stall high while the column position is
// re-split against the new column count. A center's first record passes through
// the stage 1 registers, the center queue and the registered output stage.
`default_nettype none

module watershed_boundary_detect import wbd_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  // configuration
  input  wire                           cfg_write,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data,
  // cell requests
  input  wire                           cell_valid,
  output logic                          cell_stall,
  input  wire                           mode,
  input  wire logic signed [LABEL_W-1:0] cell_label,
  input  wire logic signed [ELEV_W-1:0] cell_elevation,
  // boundary records
  output logic                          rec_valid,
  input  wire                           rec_stall,
  output logic [ROW_W-1:0]              out_row,
  output logic [OUT_COL_W-1:0]          out_col,
  output logic [OUT_LABEL_W-1:0]        center_label,
  output logic signed [ELEV_W-1:0]      boundary_elevation,
  output logic [OUT_LABEL_W-1:0]        other_label,
  output logic                          last_of_run
);

  logic   q_push;
  logic   q_pop;
  rec_t   q_in;
  rec_t   q_head;
  qstat_t q_stat;

  // classify centers
  wbd_front #(
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cell_valid     (cell_valid),
    .cell_stall     (cell_stall),
    .mode           (mode),
    .cell_label     (cell_label),
    .cell_elevation (cell_elevation),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_rec          (q_in)
  );

  // decouple classification from record output
  wbd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (q_in),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  // expand centers into records
  wbd_back u_back (
    .clk                (clk),
    .rst                (rst),
    .head               (q_head),
    .q_stat             (q_stat),
    .pop                (q_pop),
    .rec_valid          (rec_valid),
    .rec_stall          (rec_stall),
    .out_row            (out_row),
    .out_col            (out_col),
    .center_label       (center_label),
    .boundary_elevation (boundary_elevation),
    .other_label        (other_label),
    .last_of_run        (last_of_run)
  );

  // the front end reserves queue room before taking a cell
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_stat.count < QCNT_W'(QUEUE_DEPTH)))
    else $error("center queue overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty center queue");

  // a center leaves the queue only with its final record
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (rec_valid && last_of_run))
    else $error("center retired without last record");

  // no cell may enter before the position is re-split
  a_cfg_hold: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> cell_stall)
    else $error("cell taken right after register write");

endmodule

`default_nettype wire
